// ===== src/srtf_pkg.sv =====
// ---------------------------------------------------------------------------
// srtf_pkg
// Shared types, constants and helpers for the SRTF job scheduler.
// ---------------------------------------------------------------------------
package srtf_pkg;

    // Job table size and derived widths
    localparam int MAX_JOBS = 16;
    localparam int SLOT_W   = (MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1;
    localparam int PIDX_W   = 4;
    localparam int WORK_W   = 16;
    localparam int TICK_W   = 32;

    typedef logic [SLOT_W-1:0] t_slot;
    typedef logic [PIDX_W-1:0] t_pidx;
    typedef logic [WORK_W-1:0] t_work;
    typedef logic [TICK_W-1:0] t_tick;

    localparam t_tick TICK_MAX = '1;

    // Item commands
    typedef enum logic {
        CMD_LOAD = 1'b0,
        CMD_TICK = 1'b1
    } t_cmd;

    // Input beat
    typedef struct packed {
        t_cmd  command;
        t_pidx process_index;
        t_work arrival_at;
        t_work burst_length;
    } t_in_item;

    // Output beat
    typedef struct packed {
        t_pidx running_index;
        logic  cpu_busy;
        logic  job_finished;
        t_tick finished_waiting;
        t_tick finished_turnaround;
        logic  all_done;
    } t_out_item;

    // Controller to datapath commands
    typedef struct packed {
        logic capture;
        logic load_wr;
        logic scan_rd;
        logic update;
        logic wait_calc;
        logic form_out;
    } t_dp_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic scan_last;
    } t_dp_status;

    // Saturating increment of the time counter
    function automatic t_tick sat_inc(input t_tick v);
        return (v == TICK_MAX) ? v : v + t_tick'(1);
    endfunction

endpackage

// ===== src/srtf_scheduler_top.sv =====
// ---------------------------------------------------------------------------
// srtf_scheduler_top
// Preemptive shortest-remaining-time-first scheduler over a job table.
// ---------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_ready / i_in_data) carries one beat per
//   item: a load writes a job slot (arrival, burst), a tick runs the ready job
//   with the least remaining work (lowest slot wins a tie) and advances time.
//   Output channel (o_out_valid / i_out_ready / o_out_data) returns exactly
//   one beat per input beat, in order.
//   From accept to o_out_valid, a load steps through the load and form
//   states; a tick steps through the scan, which reads one table entry per
//   cycle through the single read port of the job memories, then drain,
//   update, wait and form. One item is in flight at a time: o_in_ready
//   drops on accept and returns in the cycle after the result beat is taken.
//   Receiver stall: the result beat holds in the output register for as long
//   as i_out_ready is low, and no new item is accepted meanwhile.
//   Reset (synchronous, active low) clears all live bits and the time
//   counter at once; no clearing pass is needed, and the block is ready in
//   the first cycle after reset.
// ---------------------------------------------------------------------------
module srtf_scheduler_top (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  srtf_pkg::t_in_item  i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output srtf_pkg::t_out_item o_out_data
);

    srtf_pkg::t_dp_cmd    w_cmd;
    srtf_pkg::t_dp_status w_status;

    // Sequencer
    srtf_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_command   (i_in_data.command),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_status    (w_status),
        .o_cmd       (w_cmd)
    );

    // Datapath
    srtf_dp u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (i_in_data),
        .i_cmd    (w_cmd),
        .o_status (w_status),
        .o_item   (o_out_data)
    );

endmodule

// ===== src/srtf_ctrl.sv =====
// ---------------------------------------------------------------------------
// srtf_ctrl
// Sequencer for the scheduler: accepts one beat, steps the datapath through
// load or scan/update, then holds the result until the receiver takes it.
// ---------------------------------------------------------------------------
module srtf_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    input  srtf_pkg::t_cmd       i_command,
    output logic                 o_in_ready,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    input  srtf_pkg::t_dp_status i_status,
    output srtf_pkg::t_dp_cmd    o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOAD,
        S_SCAN,
        S_DRAIN,
        S_UPDATE,
        S_WAIT,
        S_FORM,
        S_OUT
    } t_state;

    t_state r_state;
    logic   r_in_ready;
    logic   r_out_valid;
    logic   w_accept;

    assign w_accept    = r_in_ready & i_in_valid;
    assign o_in_ready  = r_in_ready;
    assign o_out_valid = r_out_valid;

    // Decode datapath commands from the current state
    always_comb begin
        o_cmd = '0;
        case (r_state)
            S_IDLE:   o_cmd.capture   = w_accept;
            S_LOAD:   o_cmd.load_wr   = 1'b1;
            S_SCAN:   o_cmd.scan_rd   = 1'b1;
            S_DRAIN:  o_cmd           = '0;
            S_UPDATE: o_cmd.update    = 1'b1;
            S_WAIT:   o_cmd.wait_calc = 1'b1;
            S_FORM:   o_cmd.form_out  = 1'b1;
            S_OUT:    o_cmd           = '0;
            default:  o_cmd           = '0;
        endcase
    end

    // State and handshake registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_in_ready  <= 1'b1;
            r_out_valid <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_in_ready <= 1'b0;
                        r_state    <= (i_command == srtf_pkg::CMD_LOAD) ? S_LOAD : S_SCAN;
                    end
                end
                S_LOAD:   r_state <= S_FORM;
                S_SCAN: begin
                    if (i_status.scan_last) begin
                        r_state <= S_DRAIN;
                    end
                end
                S_DRAIN:  r_state <= S_UPDATE;
                S_UPDATE: r_state <= S_WAIT;
                S_WAIT:   r_state <= S_FORM;
                S_FORM: begin
                    r_out_valid <= 1'b1;
                    r_state     <= S_OUT;
                end
                S_OUT: begin
                    if (i_out_ready) begin
                        r_out_valid <= 1'b0;
                        r_in_ready  <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state     <= S_IDLE;
                    r_in_ready  <= 1'b1;
                    r_out_valid <= 1'b0;
                end
            endcase
        end
    end

endmodule

// ===== src/srtf_dp.sv =====
// ---------------------------------------------------------------------------
// srtf_dp
// Scheduler datapath: job table memories, live bits, time counter, the
// sequential minimum search and the completion arithmetic.
// ---------------------------------------------------------------------------
module srtf_dp (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  srtf_pkg::t_in_item   i_item,
    input  srtf_pkg::t_dp_cmd    i_cmd,
    output srtf_pkg::t_dp_status o_status,
    output srtf_pkg::t_out_item  o_item
);

    // Job table, no reset: entries are read only behind a set live bit
    srtf_pkg::t_work mem_rem [srtf_pkg::MAX_JOBS];
    srtf_pkg::t_work mem_arr [srtf_pkg::MAX_JOBS];
    srtf_pkg::t_work mem_bur [srtf_pkg::MAX_JOBS];

    logic [srtf_pkg::MAX_JOBS-1:0] r_live;
    srtf_pkg::t_tick               r_now;

    // Captured beat
    srtf_pkg::t_slot r_slot;
    logic            r_slot_ok;
    srtf_pkg::t_work r_arr;
    srtf_pkg::t_work r_bur;

    // Scan pipeline
    srtf_pkg::t_slot r_scan;
    logic            r_p_valid;
    logic            r_p_live;
    srtf_pkg::t_slot r_p_idx;
    srtf_pkg::t_work r_p_rem;
    srtf_pkg::t_work r_p_arr;
    srtf_pkg::t_work r_p_bur;

    // Best candidate
    logic            r_found;
    srtf_pkg::t_slot r_best_idx;
    srtf_pkg::t_work r_best_rem;
    srtf_pkg::t_work r_best_arr;
    srtf_pkg::t_work r_best_bur;

    // Tick results
    logic            r_busy;
    logic            r_fin;
    srtf_pkg::t_tick r_turn;
    srtf_pkg::t_tick r_wait;

    srtf_pkg::t_out_item r_out;

    logic            w_eligible;
    logic            w_better;
    logic            w_wr_en;
    srtf_pkg::t_slot w_wr_addr;
    srtf_pkg::t_work w_wr_rem;
    srtf_pkg::t_tick w_finish;
    srtf_pkg::t_work w_rem_dec;

    assign o_status.scan_last = (r_scan == srtf_pkg::t_slot'(srtf_pkg::MAX_JOBS - 1));
    assign o_item             = r_out;

    // Compare the entry read last cycle against the best so far
    assign w_eligible = r_p_valid & r_p_live & (srtf_pkg::t_tick'(r_p_arr) <= r_now);
    assign w_better   = w_eligible & (!r_found || (r_p_rem < r_best_rem));

    assign w_rem_dec = r_best_rem - srtf_pkg::t_work'(1);
    assign w_finish  = srtf_pkg::sat_inc(r_now);

    // Single write port: load or decrement of the chosen job
    assign w_wr_en   = (i_cmd.load_wr & r_slot_ok) | (i_cmd.update & r_found);
    assign w_wr_addr = i_cmd.load_wr ? r_slot : r_best_idx;
    assign w_wr_rem  = i_cmd.load_wr ? r_bur : w_rem_dec;

    // Table memories: one write, one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            mem_rem[w_wr_addr] <= w_wr_rem;
        end
        if (i_cmd.load_wr && r_slot_ok) begin
            mem_arr[r_slot] <= r_arr;
            mem_bur[r_slot] <= r_bur;
        end
        r_p_rem <= mem_rem[r_scan];
        r_p_arr <= mem_arr[r_scan];
        r_p_bur <= mem_bur[r_scan];
        r_p_idx <= r_scan;
    end

    // Control state: live bits, time, scan valid, found flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_live    <= '0;
            r_now     <= '0;
            r_p_valid <= 1'b0;
            r_p_live  <= 1'b0;
            r_found   <= 1'b0;
            r_scan    <= '0;
        end else begin
            r_p_valid <= i_cmd.scan_rd;
            r_p_live  <= r_live[r_scan];
            if (i_cmd.capture) begin
                r_found <= 1'b0;
                r_scan  <= '0;
            end else begin
                if (i_cmd.scan_rd) begin
                    r_scan <= r_scan + srtf_pkg::t_slot'(1);
                end
                if (w_better) begin
                    r_found <= 1'b1;
                end
            end
            if (i_cmd.load_wr && r_slot_ok) begin
                r_live[r_slot] <= (r_bur != '0);
            end
            if (i_cmd.update) begin
                r_now <= w_finish;
                if (r_found && (w_rem_dec == '0)) begin
                    r_live[r_best_idx] <= 1'b0;
                end
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        // Capture the beat and clear per-item results
        if (i_cmd.capture) begin
            r_slot    <= srtf_pkg::t_slot'(i_item.process_index);
            r_slot_ok <= (32'(i_item.process_index) < srtf_pkg::MAX_JOBS);
            r_arr     <= i_item.arrival_at;
            r_bur     <= i_item.burst_length;
            r_busy    <= 1'b0;
            r_fin     <= 1'b0;
            r_turn    <= '0;
            r_wait    <= '0;
        end
        // Hold the best candidate
        if (w_better) begin
            r_best_idx <= r_p_idx;
            r_best_rem <= r_p_rem;
            r_best_arr <= r_p_arr;
            r_best_bur <= r_p_bur;
        end
        // Run the chosen job and compute turnaround on completion
        if (i_cmd.update && r_found) begin
            r_busy <= 1'b1;
            if (w_rem_dec == '0) begin
                r_fin  <= 1'b1;
                r_turn <= w_finish - srtf_pkg::t_tick'(r_best_arr);
            end
        end
        // Waiting time, clamped at zero
        if (i_cmd.wait_calc && r_fin) begin
            r_wait <= (r_turn >= srtf_pkg::t_tick'(r_best_bur))
                    ? r_turn - srtf_pkg::t_tick'(r_best_bur) : '0;
        end
        // Form the result beat
        if (i_cmd.form_out) begin
            r_out.running_index       <= r_busy ? srtf_pkg::t_pidx'(r_best_idx) : '0;
            r_out.cpu_busy            <= r_busy;
            r_out.job_finished        <= r_fin;
            r_out.finished_waiting    <= r_wait;
            r_out.finished_turnaround <= r_turn;
            r_out.all_done            <= ~|r_live;
        end
    end

endmodule

// ===== src/srtf_checker.sv =====
// ---------------------------------------------------------------------------
// srtf_checker
// Port-level checks on the scheduler's handshake and result beats.
// ---------------------------------------------------------------------------
module srtf_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_valid,
    input logic                o_in_ready,
    input logic                o_out_valid,
    input logic                i_out_ready,
    input srtf_pkg::t_out_item o_out_data
);

    // Hold a stalled result beat
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_out_data)))
        else $error("result beat dropped or changed under stall");

    // Take no new beat while a result is pending
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !o_in_ready)
        else $error("input ready while result pending");

    // One beat in flight: ready drops after an accept
    a_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("second beat accepted while busy");

    // Completion only when a job ran
    a_fin_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.job_finished) |-> o_out_data.cpu_busy)
        else $error("job finished without running");

    // Waiting never exceeds turnaround
    a_wait_le_turn: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.job_finished)
            |-> (o_out_data.finished_waiting <= o_out_data.finished_turnaround))
        else $error("waiting exceeds turnaround");

endmodule

bind srtf_scheduler_top srtf_checker u_srtf_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data)
);

// ===== sim/srtf_scheduler_top_tb.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// srtf_scheduler_top_tb
// Self-checking bench for the SRTF job scheduler. A stimulus process queues
// load and tick beats, first a short directed sweep and then random job
// phases with small bursts and near-term arrivals, mixed with random loads
// that get cleared afterward. A driver offers the queued beats with random
// gaps. A shadow job table predicts each result beat, and the monitor
// compares the results field by field, in order, with random receiver stalls
// and one long hold-off.
// ---------------------------------------------------------------------------
module srtf_scheduler_top_tb;

    localparam int RANDOM_ITEMS = 850;
    localparam int STALL_LIMIT  = 1000;
    localparam int LONG_HOLD    = 150;
    localparam int HOLD_AFTER   = 300;

    typedef struct {
        srtf_pkg::t_in_item beat;
        bit                 drain_first;
    } t_pending;

    logic                i_clk;
    logic                i_rst_n     = 1'b0;
    logic                i_in_valid  = 1'b0;
    logic                o_in_ready;
    srtf_pkg::t_in_item  i_in_data   = '0;
    logic                o_out_valid;
    logic                i_out_ready = 1'b0;
    srtf_pkg::t_out_item o_out_data;

    // Shadow job table
    srtf_pkg::t_work job_left    [srtf_pkg::MAX_JOBS] = '{default: '0};
    srtf_pkg::t_work job_arrival [srtf_pkg::MAX_JOBS] = '{default: '0};
    srtf_pkg::t_work job_burst   [srtf_pkg::MAX_JOBS] = '{default: '0};
    srtf_pkg::t_tick sim_now = '0;

    t_pending            pending_items[$];
    srtf_pkg::t_out_item due_results[$];

    logic in_taken  = 1'b0;
    logic out_taken = 1'b0;
    int   mismatch_count = 0;
    int   results_seen   = 0;
    int   stall_cycles   = 0;
    int   send_gap       = 0;
    int   take_wait      = 0;
    bit   beat_stalled   = 1'b0;
    bit   long_hold_done = 1'b0;
    bit   quiet_phase    = 1'b0;
    bit   drain_next     = 1'b0;
    int   items_made     = 0;
    int   plan_now       = 0;

    srtf_scheduler_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Apply one beat to the shadow table and return the result it yields
    function automatic srtf_pkg::t_out_item schedule_step(input srtf_pkg::t_in_item it);
        srtf_pkg::t_out_item r;
        logic                found;
        int                  pick;
        srtf_pkg::t_work     pick_left;
        srtf_pkg::t_tick     finish;
        srtf_pkg::t_tick     turn;
        r = '0;
        if (it.command == srtf_pkg::CMD_LOAD) begin
            if (int'(it.process_index) < srtf_pkg::MAX_JOBS) begin
                job_arrival[it.process_index] = it.arrival_at;
                job_burst[it.process_index]   = it.burst_length;
                job_left[it.process_index]    = it.burst_length;
            end
        end else begin
            found     = 1'b0;
            pick      = 0;
            pick_left = '0;
            // Least remaining work among arrived jobs; lowest slot wins a tie
            for (int s = 0; s < srtf_pkg::MAX_JOBS; s++) begin
                if (job_left[s] != '0 && srtf_pkg::t_tick'(job_arrival[s]) <= sim_now &&
                    (!found || job_left[s] < pick_left)) begin
                    found     = 1'b1;
                    pick      = s;
                    pick_left = job_left[s];
                end
            end
            if (found) begin
                r.running_index = srtf_pkg::t_pidx'(pick);
                r.cpu_busy      = 1'b1;
                job_left[pick]  = pick_left - srtf_pkg::t_work'(1);
                if (job_left[pick] == '0) begin
                    finish = (sim_now == '1) ? sim_now : sim_now + srtf_pkg::t_tick'(1);
                    turn   = finish - srtf_pkg::t_tick'(job_arrival[pick]);
                    r.job_finished        = 1'b1;
                    r.finished_turnaround = turn;
                    r.finished_waiting    =
                        (turn >= srtf_pkg::t_tick'(job_burst[pick])) ?
                        turn - srtf_pkg::t_tick'(job_burst[pick]) : '0;
                end
            end
            sim_now = (sim_now == '1) ? sim_now : sim_now + srtf_pkg::t_tick'(1);
        end
        r.all_done = 1'b1;
        for (int s = 0; s < srtf_pkg::MAX_JOBS; s++) begin
            if (job_left[s] != '0) r.all_done = 1'b0;
        end
        return r;
    endfunction

    task automatic report_mismatch(input string field, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("result %0d: %s got 0x%0h, expected 0x%0h",
                 results_seen, field, got, want);
        mismatch_count++;
    endtask

    task automatic push_beat(input srtf_pkg::t_cmd cmd, input int unsigned idx,
                             input int unsigned arr, input int unsigned bur);
        t_pending p;
        p.beat.command       = cmd;
        p.beat.process_index = srtf_pkg::t_pidx'(idx);
        p.beat.arrival_at    = srtf_pkg::t_work'(arr);
        p.beat.burst_length  = srtf_pkg::t_work'(bur);
        p.drain_first        = drain_next;
        drain_next           = 1'b0;
        pending_items.push_back(p);
        if (cmd == srtf_pkg::CMD_TICK) plan_now++;
        items_made++;
    endtask

    // Ticks carry random payload, which the block must ignore
    task automatic push_ticks(input int unsigned n);
        repeat (n) begin
            push_beat(srtf_pkg::CMD_TICK, $urandom_range(0, 15),
                      $urandom_range(0, 65535), $urandom_range(0, 65535));
        end
    endtask

    // Drive input beats at the falling edge; hold each until accepted
    always @(negedge i_clk) begin : drv_proc
        t_pending nxt;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (i_in_valid && !in_taken) begin
            // hold
        end else begin
            if (i_in_valid) send_gap = quiet_phase ? 0 : $urandom_range(0, 3);
            if (send_gap > 0) begin
                send_gap--;
                i_in_valid <= 1'b0;
            end else if (pending_items.size() != 0 &&
                         !(pending_items[0].drain_first && due_results.size() != 0)) begin
                nxt = pending_items.pop_front();
                i_in_data  <= nxt.beat;
                i_in_valid <= 1'b1;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // Stall each result beat a random number of cycles, once for a long stretch
    always @(negedge i_clk) begin : rcv_proc
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (out_taken) beat_stalled = 1'b0;
            if (o_out_valid && !beat_stalled) begin
                beat_stalled = 1'b1;
                if (!long_hold_done && results_seen >= HOLD_AFTER) begin
                    take_wait      = LONG_HOLD;
                    long_hold_done = 1'b1;
                end else begin
                    take_wait = quiet_phase ? 0 : $urandom_range(0, 3);
                end
            end
            if (take_wait > 0) begin
                take_wait--;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    // Check result beats against the oldest prediction; predict accepted beats
    always @(posedge i_clk) begin : mon_proc
        srtf_pkg::t_out_item want;
        in_taken  <= i_rst_n && i_in_valid && o_in_ready;
        out_taken <= i_rst_n && o_out_valid && i_out_ready;
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready) begin
                if (due_results.size() == 0) begin
                    report_mismatch("unexpected beat", 64'(o_out_data), 64'(0));
                end else begin
                    want = due_results.pop_front();
                    if (o_out_data.running_index !== want.running_index)
                        report_mismatch("running_index", 64'(o_out_data.running_index),
                                        64'(want.running_index));
                    if (o_out_data.cpu_busy !== want.cpu_busy)
                        report_mismatch("cpu_busy", 64'(o_out_data.cpu_busy),
                                        64'(want.cpu_busy));
                    if (o_out_data.job_finished !== want.job_finished)
                        report_mismatch("job_finished", 64'(o_out_data.job_finished),
                                        64'(want.job_finished));
                    if (o_out_data.finished_waiting !== want.finished_waiting)
                        report_mismatch("finished_waiting",
                                        64'(o_out_data.finished_waiting),
                                        64'(want.finished_waiting));
                    if (o_out_data.finished_turnaround !== want.finished_turnaround)
                        report_mismatch("finished_turnaround",
                                        64'(o_out_data.finished_turnaround),
                                        64'(want.finished_turnaround));
                    if (o_out_data.all_done !== want.all_done)
                        report_mismatch("all_done", 64'(o_out_data.all_done),
                                        64'(want.all_done));
                end
                results_seen++;
            end
            if (i_in_valid && o_in_ready) due_results.push_back(schedule_step(i_in_data));
        end
    end

    // End the run when no beat moves for too long
    always @(posedge i_clk) begin : watchdog_proc
        if (!i_rst_n || in_taken || out_taken) stall_cycles <= 0;
        else stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("srtf_scheduler_top_tb: FAIL");
            $finish;
        end
    end

    initial begin : stim_proc
        int          n_jobs;
        int          work_sum;
        int          arr;
        int          bur;
        int          slot;
        int          phase;
        logic [15:0] noise_mask;

        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Idle tick on an empty table
        push_ticks(1);
        // Empty load, then a job that never arrives with maximal fields
        push_beat(srtf_pkg::CMD_LOAD, 0, 0, 0);
        push_beat(srtf_pkg::CMD_LOAD, 15, 65535, 65535);
        // Equal bursts: the lower slot wins the tie
        push_beat(srtf_pkg::CMD_LOAD, 3, 0, 3);
        push_beat(srtf_pkg::CMD_LOAD, 5, 0, 3);
        push_ticks(2);
        // Overwrite a live slot, then add a short job that preempts later
        push_beat(srtf_pkg::CMD_LOAD, 5, 1, 2);
        push_beat(srtf_pkg::CMD_LOAD, 7, 4, 1);
        push_ticks(4);
        // Late arrival after an idle gap must still be served
        push_beat(srtf_pkg::CMD_LOAD, 9, 12, 1);
        push_ticks(7);
        // Clear the far-future job so the table drains
        push_beat(srtf_pkg::CMD_LOAD, 15, 0, 0);

        // Random job phases
        phase = 0;
        while (items_made < 22 + RANDOM_ITEMS) begin
            quiet_phase = ($urandom_range(0, 4) == 0);
            drain_next  = (phase == 0) || ($urandom_range(0, 3) == 0);
            n_jobs      = $urandom_range(1, 6);
            work_sum    = 0;
            noise_mask  = '0;
            for (int j = 0; j < n_jobs; j++) begin
                push_ticks($urandom_range(0, 2));
                slot = $urandom_range(0, 15);
                if ($urandom_range(0, 7) == 0) begin
                    // Random fields; cleared at the end of the phase
                    noise_mask[slot] = 1'b1;
                    push_beat(srtf_pkg::CMD_LOAD, slot, $urandom_range(0, 65535),
                              $urandom_range(0, 65535));
                end else begin
                    bur = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 6);
                    arr = plan_now + $urandom_range(0, 6) - 2;
                    if (arr < 0) arr = 0;
                    push_beat(srtf_pkg::CMD_LOAD, slot, arr, bur);
                    work_sum += bur;
                end
            end
            push_ticks(work_sum + $urandom_range(2, 6));
            for (int s = 0; s < srtf_pkg::MAX_JOBS; s++) begin
                if (noise_mask[s]) begin
                    push_beat(srtf_pkg::CMD_LOAD, s, $urandom_range(0, 65535), 0);
                end
            end
            phase++;
            while (pending_items.size() > 24) @(posedge i_clk);
        end

        // Drain: all beats offered, all results back, then settle
        while (pending_items.size() != 0 || i_in_valid) @(posedge i_clk);
        while (due_results.size() != 0) @(posedge i_clk);
        repeat (30) @(posedge i_clk);
        if (mismatch_count == 0 && due_results.size() == 0) begin
            $display("srtf_scheduler_top_tb: PASS");
        end else begin
            $display("srtf_scheduler_top_tb: FAIL");
        end
        $finish;
    end

endmodule
